// File: rtl/kcsi_pkg.sv
// ----------------------------------------------------------------------------
// kcsi_pkg
// Shared types and codes for the keyframe cardinal spline interpolator.
// ----------------------------------------------------------------------------
package kcsi_pkg;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic CFG_TENSION   = 1'b0;
  localparam logic CFG_KEY_COUNT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_RNG0, S_RNG1, S_RNG2, S_SRA, S_SRB,
    S_F0, S_F1, S_F2, S_F3, S_F4, S_CALC, S_WAIT, S_FIN, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    ST_DIV_R1, ST_MUL_F1, ST_DIV_R2, ST_MUL_F2, ST_DIV_S, ST_MUL_S2, ST_MUL_S3,
    ST_MUL_D1, ST_MUL_D2, ST_MUL_H0, ST_MUL_H1, ST_MUL_H2, ST_MUL_H3
  } step_t;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic               start;
    alu_op_t            op;
    logic signed [39:0] a;
    logic signed [39:0] b;
    logic [4:0]         sh;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic        neg;
    logic [71:0] mag;
  } alu_rsp_t;

endpackage

// File: rtl/keyframe_cardinal_spline_interp.sv
// ----------------------------------------------------------------------------
// keyframe_cardinal_spline_interp
// Keyframe store and cardinal Hermite spline evaluation in Q16.16.
//
//   channel  dir  handshake              payload
//   in       in   in_tvalid/in_tready    in_tdata, in_tuser (op)
//   out      out  out_tvalid/out_tready  out_tdata, out_tuser (status)
//   cfg      in   cfg_we                 cfg_addr, cfg_wdata
//
// a load word is written to the key store when it is accepted; a query runs a
// linear key search through the single ram read port, then uses the shared
// multiply/divide unit (two 30-bit and one 24-bit divide, 22 multiplies); an
// out-of-range query goes straight to the result register
// synchronous reset restores tension 1.2 and key_count 7; key store is not reset
// the result register holds a word until out_tready; a new word is taken
// while it waits, and the next result waits for the register to free up
// ----------------------------------------------------------------------------
module keyframe_cardinal_spline_interp #(
  parameter int MAX_KEYS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // key_index[5:0], key_time[37:6], key_x[69:38], key_y[101:70],
  // key_z[133:102], query_time[165:134]
  input  logic [167:0] in_tdata,
  // op[0]
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64]
  output logic [95:0]  out_tdata,
  // status[0]
  output logic         out_tuser,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [15:0]  cfg_wdata
);

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int NW = $clog2(MAX_KEYS + 1);
  localparam int IW = (AW > 6) ? AW : 6;

  kcsi_pkg::state_t state_r, state_nxt;
  kcsi_pkg::step_t  step_r;
  kcsi_pkg::alu_req_t alu_req;
  kcsi_pkg::alu_rsp_t alu_rsp;

  logic [15:0] tension_r;
  logic [6:0]  key_count_r;

  logic [AW-1:0]  k_r;
  logic [1:0]     ax_r;
  logic [31:0]    tq_r;
  logic [31:0]    tfirst_r;
  logic [31:0]    t_r  [4];
  logic [31:0]    pa_r [4];
  logic [31:0]    pb_r [4];
  logic [31:0]    pc_r [4];
  logic [30:0]    r_r;
  logic [24:0]    f1_r, f2_r, s_r, s2_r, s3_r;
  logic signed [39:0] d1_r, d2_r;
  logic signed [71:0] acc_r;
  logic [31:0]    res_x_r, res_y_r, res_z_r;
  logic           status_r;

  logic           out_tvalid_r;
  logic [95:0]    out_tdata_r;
  logic           out_tuser_r;

  logic [NW-1:0]  n_w;
  logic           k_lt;
  logic [AW-1:0]  i0_w, i3_w, raddr;
  logic [127:0]   rdata;
  logic [31:0]    rd_t;
  logic           wr_ok, ram_we;
  logic [IW-1:0]  idx_ext;
  logic           accept;
  logic           oor;

  logic signed [39:0] dt21, dt20, dt31, dtq1, dp20, dp31, p1e, p2e;
  logic signed [27:0] s_e, s2_e, s3_e, h00, h10, h01, h11;
  logic signed [72:0] rnd20, rnd22, rnd24, pfull, fin;
  logic signed [71:0] prod;
  logic [71:0]        acc_mag;
  logic [31:0]        fin_sat;

  function automatic logic signed [72:0] rshift(input logic [71:0] mag, input logic neg,
                                                input int sh);
    logic [72:0] m;
    m = ({1'b0, mag} + (73'd1 << (sh - 1))) >> sh;
    return neg ? -$signed(m) : $signed(m);
  endfunction

  assign accept  = in_tvalid && in_tready;
  assign idx_ext = IW'(in_tdata[5:0]);
  assign wr_ok   = 32'(in_tdata[5:0]) < MAX_KEYS;
  assign ram_we  = accept && (in_tuser == kcsi_pkg::OP_LOAD) && wr_ok;

  kcsi_ram #(
    .WIDTH (128),
    .DEPTH (MAX_KEYS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_ext[AW-1:0]),
    .wdata (in_tdata[133:6]),
    .raddr (raddr),
    .rdata (rdata)
  );

  kcsi_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  assign rd_t = rdata[31:0];

  assign n_w = (key_count_r < 7'd3) ? NW'(3) :
               (32'(key_count_r) > MAX_KEYS) ? NW'(MAX_KEYS) : NW'(key_count_r);
  assign k_lt = (NW'(k_r) + NW'(2)) < n_w;
  assign i0_w = (k_r == '0) ? '0 : k_r - AW'(1);
  assign i3_w = (k_r == '0 || k_lt) ? k_r + AW'(2) : k_r + AW'(1);
  assign oor  = (tq_r < tfirst_r) || (tq_r > rd_t);

  assign dt21 = $signed({8'h00, t_r[2]}) - $signed({8'h00, t_r[1]});
  assign dt20 = $signed({8'h00, t_r[2]}) - $signed({8'h00, t_r[0]});
  assign dt31 = $signed({8'h00, t_r[3]}) - $signed({8'h00, t_r[1]});
  assign dtq1 = $signed({8'h00, tq_r})   - $signed({8'h00, t_r[1]});
  assign p1e  = {{8{pa_r[1][31]}}, pa_r[1]};
  assign p2e  = {{8{pa_r[2][31]}}, pa_r[2]};
  assign dp20 = p2e - {{8{pa_r[0][31]}}, pa_r[0]};
  assign dp31 = {{8{pa_r[3][31]}}, pa_r[3]} - p1e;

  assign s_e  = {3'b000, s_r};
  assign s2_e = {3'b000, s2_r};
  assign s3_e = {3'b000, s3_r};
  assign h00  = (s3_e <<< 1) - (s2_e + (s2_e <<< 1)) + 28'sd16777216;
  assign h10  = s3_e - (s2_e <<< 1) + s_e;
  assign h01  = (s2_e + (s2_e <<< 1)) - (s3_e <<< 1);
  assign h11  = s3_e - s2_e;

  assign rnd20 = rshift(alu_rsp.mag, alu_rsp.neg, 20);
  assign rnd22 = rshift(alu_rsp.mag, alu_rsp.neg, 22);
  assign rnd24 = rshift(alu_rsp.mag, alu_rsp.neg, 24);
  assign pfull = alu_rsp.neg ? -$signed({1'b0, alu_rsp.mag}) : $signed({1'b0, alu_rsp.mag});
  assign prod  = pfull[71:0];

  assign acc_mag = acc_r[71] ? 72'(-acc_r) : 72'(acc_r);
  assign fin     = rshift(acc_mag, acc_r[71], 24);
  assign fin_sat = (fin > 73'sd2147483647)  ? 32'h7fff_ffff :
                   (fin < -73'sd2147483648) ? 32'h8000_0000 : fin[31:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kcsi_pkg::S_IDLE: begin
        if (in_tvalid && in_tuser == kcsi_pkg::OP_QUERY) begin
          state_nxt = kcsi_pkg::S_RNG0;
        end
      end
      kcsi_pkg::S_RNG0: state_nxt = kcsi_pkg::S_RNG1;
      kcsi_pkg::S_RNG1: state_nxt = kcsi_pkg::S_RNG2;
      kcsi_pkg::S_RNG2: state_nxt = oor ? kcsi_pkg::S_OUT : kcsi_pkg::S_SRA;
      kcsi_pkg::S_SRA:  state_nxt = k_lt ? kcsi_pkg::S_SRB : kcsi_pkg::S_F0;
      kcsi_pkg::S_SRB:  state_nxt = (rd_t < tq_r) ? kcsi_pkg::S_SRA : kcsi_pkg::S_F0;
      kcsi_pkg::S_F0:   state_nxt = kcsi_pkg::S_F1;
      kcsi_pkg::S_F1:   state_nxt = kcsi_pkg::S_F2;
      kcsi_pkg::S_F2:   state_nxt = kcsi_pkg::S_F3;
      kcsi_pkg::S_F3:   state_nxt = kcsi_pkg::S_F4;
      kcsi_pkg::S_F4:   state_nxt = kcsi_pkg::S_CALC;
      kcsi_pkg::S_CALC: state_nxt = kcsi_pkg::S_WAIT;
      kcsi_pkg::S_WAIT: begin
        if (alu_rsp.done) begin
          state_nxt = (step_r == kcsi_pkg::ST_MUL_H3) ? kcsi_pkg::S_FIN : kcsi_pkg::S_CALC;
        end
      end
      kcsi_pkg::S_FIN:  state_nxt = (ax_r == 2'd2) ? kcsi_pkg::S_OUT : kcsi_pkg::S_CALC;
      kcsi_pkg::S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = kcsi_pkg::S_IDLE;
        end
      end
      default: state_nxt = kcsi_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready     = (state_r == kcsi_pkg::S_IDLE);
    raddr         = '0;
    alu_req.start = (state_r == kcsi_pkg::S_CALC);
    alu_req.op    = kcsi_pkg::ALU_MUL;
    alu_req.a     = '0;
    alu_req.b     = '0;
    alu_req.sh    = 5'd30;
    case (state_r)
      kcsi_pkg::S_RNG0: raddr = '0;
      kcsi_pkg::S_RNG1: raddr = AW'(n_w - NW'(1));
      kcsi_pkg::S_SRA:  raddr = k_r + AW'(1);
      kcsi_pkg::S_F0:   raddr = i0_w;
      kcsi_pkg::S_F1:   raddr = k_r;
      kcsi_pkg::S_F2:   raddr = k_r + AW'(1);
      kcsi_pkg::S_F3:   raddr = i3_w;
      default:          raddr = '0;
    endcase
    case (step_r)
      kcsi_pkg::ST_DIV_R1: begin
        alu_req.op = kcsi_pkg::ALU_DIV;
        alu_req.a  = dt21;
        alu_req.b  = dt20;
      end
      kcsi_pkg::ST_MUL_F1, kcsi_pkg::ST_MUL_F2: begin
        alu_req.a = $signed({9'd0, r_r});
        alu_req.b = $signed({24'd0, tension_r});
      end
      kcsi_pkg::ST_DIV_R2: begin
        alu_req.op = kcsi_pkg::ALU_DIV;
        alu_req.a  = dt21;
        alu_req.b  = dt31;
      end
      kcsi_pkg::ST_DIV_S: begin
        alu_req.op = kcsi_pkg::ALU_DIV;
        alu_req.a  = dtq1;
        alu_req.b  = dt21;
        alu_req.sh = 5'd24;
      end
      kcsi_pkg::ST_MUL_S2: begin
        alu_req.a = $signed({15'd0, s_r});
        alu_req.b = $signed({15'd0, s_r});
      end
      kcsi_pkg::ST_MUL_S3: begin
        alu_req.a = $signed({15'd0, s2_r});
        alu_req.b = $signed({15'd0, s_r});
      end
      kcsi_pkg::ST_MUL_D1: begin
        alu_req.a = dp20;
        alu_req.b = $signed({15'd0, f1_r});
      end
      kcsi_pkg::ST_MUL_D2: begin
        alu_req.a = dp31;
        alu_req.b = $signed({15'd0, f2_r});
      end
      kcsi_pkg::ST_MUL_H0: begin
        alu_req.a = p1e;
        alu_req.b = 40'(h00);
      end
      kcsi_pkg::ST_MUL_H1: begin
        alu_req.a = d1_r;
        alu_req.b = 40'(h10);
      end
      kcsi_pkg::ST_MUL_H2: begin
        alu_req.a = p2e;
        alu_req.b = 40'(h01);
      end
      kcsi_pkg::ST_MUL_H3: begin
        alu_req.a = d2_r;
        alu_req.b = 40'(h11);
      end
      default: begin
        alu_req.a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= kcsi_pkg::S_IDLE;
      tension_r    <= 16'd4915;
      key_count_r  <= 7'd7;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          kcsi_pkg::CFG_TENSION:   tension_r   <= cfg_wdata;
          kcsi_pkg::CFG_KEY_COUNT: key_count_r <= cfg_wdata[6:0];
          default:                 tension_r   <= tension_r;
        endcase
      end
      if (state_r == kcsi_pkg::S_OUT && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      kcsi_pkg::S_IDLE: begin
        tq_r     <= in_tdata[165:134];
        k_r      <= '0;
        status_r <= 1'b0;
      end
      kcsi_pkg::S_RNG1: tfirst_r <= rd_t;
      kcsi_pkg::S_RNG2: begin
        if (oor) begin
          status_r <= 1'b1;
          res_x_r  <= '0;
          res_y_r  <= '0;
          res_z_r  <= '0;
        end
      end
      kcsi_pkg::S_SRB: begin
        if (rd_t < tq_r) begin
          k_r <= k_r + AW'(1);
        end
      end
      kcsi_pkg::S_F1: begin
        t_r[0] <= rdata[31:0]; pa_r[0] <= rdata[63:32];
        pb_r[0] <= rdata[95:64]; pc_r[0] <= rdata[127:96];
      end
      kcsi_pkg::S_F2: begin
        t_r[1] <= rdata[31:0]; pa_r[1] <= rdata[63:32];
        pb_r[1] <= rdata[95:64]; pc_r[1] <= rdata[127:96];
      end
      kcsi_pkg::S_F3: begin
        t_r[2] <= rdata[31:0]; pa_r[2] <= rdata[63:32];
        pb_r[2] <= rdata[95:64]; pc_r[2] <= rdata[127:96];
      end
      kcsi_pkg::S_F4: begin
        t_r[3] <= rdata[31:0]; pa_r[3] <= rdata[63:32];
        pb_r[3] <= rdata[95:64]; pc_r[3] <= rdata[127:96];
        step_r <= kcsi_pkg::ST_DIV_R1;
        ax_r   <= 2'd0;
      end
      kcsi_pkg::S_WAIT: begin
        if (alu_rsp.done) begin
          if (step_r != kcsi_pkg::ST_MUL_H3) begin
            step_r <= kcsi_pkg::step_t'(step_r + 4'd1);
          end
          case (step_r)
            kcsi_pkg::ST_DIV_R1, kcsi_pkg::ST_DIV_R2: r_r <= alu_rsp.mag[30:0];
            kcsi_pkg::ST_MUL_F1: f1_r  <= rnd22[24:0];
            kcsi_pkg::ST_MUL_F2: f2_r  <= rnd22[24:0];
            kcsi_pkg::ST_DIV_S:  s_r   <= alu_rsp.mag[24:0];
            kcsi_pkg::ST_MUL_S2: s2_r  <= rnd24[24:0];
            kcsi_pkg::ST_MUL_S3: s3_r  <= rnd24[24:0];
            kcsi_pkg::ST_MUL_D1: d1_r  <= rnd20[39:0];
            kcsi_pkg::ST_MUL_D2: d2_r  <= rnd20[39:0];
            kcsi_pkg::ST_MUL_H0: acc_r <= prod;
            default:             acc_r <= acc_r + prod;
          endcase
        end
      end
      kcsi_pkg::S_FIN: begin
        res_z_r <= fin_sat;
        res_y_r <= res_z_r;
        res_x_r <= res_y_r;
        pa_r    <= pb_r;
        pb_r    <= pc_r;
        ax_r    <= ax_r + 2'd1;
        step_r  <= kcsi_pkg::ST_MUL_D1;
      end
      kcsi_pkg::S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tdata_r <= {res_z_r, res_y_r, res_x_r};
          out_tuser_r <= status_r;
        end
      end
      default: begin
        tfirst_r <= tfirst_r;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// File: rtl/kcsi_ram.sv
// ----------------------------------------------------------------------------
// kcsi_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kcsi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/kcsi_alu.sv
// ----------------------------------------------------------------------------
// kcsi_alu
// Shared arithmetic unit: sign-magnitude multiply, eight bits of the second
// operand per cycle, and restoring fractional divide, one quotient bit per
// cycle, with the ratio clamped to [0, 1].
// ----------------------------------------------------------------------------
module kcsi_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  kcsi_pkg::alu_req_t req,
  output kcsi_pkg::alu_rsp_t rsp
);

  logic                busy_r;
  logic                done_r;
  kcsi_pkg::alu_op_t   op_r;
  logic [4:0]          cnt_r;
  logic [71:0]         acc_r;
  logic [39:0]         am_r;
  logic [31:0]         bm_r;
  logic                neg_r;

  logic [39:0] a_mag;
  logic [39:0] b_mag;
  logic [47:0] pp;
  logic [35:0] rem2;
  logic        ge;
  logic        div_bad;
  logic        div_full;

  assign a_mag    = req.a[39] ? 40'(-req.a) : 40'(req.a);
  assign b_mag    = req.b[39] ? 40'(-req.b) : 40'(req.b);
  assign pp       = am_r * bm_r[31:24];
  assign rem2     = {acc_r[34:0], 1'b0};
  assign ge       = rem2 >= {2'b00, am_r[33:0]};
  assign div_bad  = req.a[39] || req.b[39] || (req.b == 40'sd0);
  assign div_full = req.a >= req.b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        if (req.op == kcsi_pkg::ALU_DIV && (div_bad || div_full)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r && cnt_r == 5'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r <= req.op;
      case (req.op)
        kcsi_pkg::ALU_MUL: begin
          am_r  <= a_mag;
          bm_r  <= b_mag[31:0];
          neg_r <= req.a[39] ^ req.b[39];
          acc_r <= '0;
          cnt_r <= 5'd4;
        end
        kcsi_pkg::ALU_DIV: begin
          neg_r <= 1'b0;
          am_r  <= 40'(req.b);
          acc_r <= 72'(req.a);
          cnt_r <= req.sh;
          if (div_bad) begin
            bm_r <= '0;
          end else if (div_full) begin
            bm_r <= 32'd1 << req.sh;
          end else begin
            bm_r <= '0;
          end
        end
        default: begin
          neg_r <= 1'b0;
        end
      endcase
    end else if (busy_r) begin
      cnt_r <= cnt_r - 5'd1;
      case (op_r)
        kcsi_pkg::ALU_MUL: begin
          acc_r <= {acc_r[63:0], 8'h00} + 72'(pp);
          bm_r  <= {bm_r[23:0], 8'h00};
        end
        kcsi_pkg::ALU_DIV: begin
          acc_r <= ge ? 72'(rem2 - {2'b00, am_r[33:0]}) : 72'(rem2);
          bm_r  <= {bm_r[30:0], ge};
        end
        default: begin
          cnt_r <= '0;
        end
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.neg  = neg_r;
  assign rsp.mag  = (op_r == kcsi_pkg::ALU_DIV) ? 72'(bm_r) : acc_r;

endmodule

// File: tb/sv/kcsi_checker.sv
// ----------------------------------------------------------------------------
// kcsi_checker
// Watches the load/query, result and register channels of the keyframe
// spline interpolator. It keeps its own key store and register copy,
// predicts each query result when the query word is accepted, and compares
// every result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module kcsi_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [167:0] in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [95:0]  out_tdata,
  input  logic         out_tuser,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [15:0]  cfg_wdata,
  output int           errors,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NKEYS = 64;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        status;
  } pos_t;

  logic [15:0] tension_q;
  logic [6:0]  count_q;
  logic [31:0] key_t [NKEYS];
  logic [31:0] key_p [3][NKEYS];
  pos_t        expected_pos [$];

  function automatic longint round_near(longint v, int sh);
    longint half;
    half = longint'(1) <<< (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  function automatic longint clamp_ratio(longint num, longint den, int sh);
    longint unsigned q;
    if (num < 0 || den <= 0) return 0;
    q = (longint'(num) << sh) / den;
    if (q > (64'd1 << sh)) q = 64'd1 << sh;
    return longint'(q);
  endfunction

  function automatic pos_t spline_eval(logic [31:0] qt);
    pos_t   r;
    int     n, k, i0, i3;
    longint t, t0, t1, t2, t3, f1, f2, s, s2, s3, h00, h10, h01, h11;
    longint p0, p1, p2, p3, d1, d2, acc;
    n = (count_q < 3) ? 3 : (count_q > NKEYS) ? NKEYS : int'(count_q);
    t = longint'(qt);
    r.x = 0; r.y = 0; r.z = 0; r.status = 1'b1;
    if (t < longint'(key_t[0]) || t > longint'(key_t[n-1])) return r;
    k = 0;
    while (k < n - 2 && longint'(key_t[k+1]) < t) k++;
    i0 = (k == 0) ? 0 : k - 1;
    i3 = (k == 0 || k < n - 2) ? k + 2 : k + 1;
    t0 = key_t[i0]; t1 = key_t[k]; t2 = key_t[k+1]; t3 = key_t[i3];
    f1 = round_near(clamp_ratio(t2 - t1, t2 - t0, 30) * longint'(tension_q), 22);
    f2 = round_near(clamp_ratio(t2 - t1, t3 - t1, 30) * longint'(tension_q), 22);
    s  = clamp_ratio(t - t1, t2 - t1, 24);
    s2 = round_near(s * s, 24);
    s3 = round_near(s2 * s, 24);
    h00 = 2 * s3 - 3 * s2 + (longint'(1) <<< 24);
    h10 = s3 - 2 * s2 + s;
    h01 = -2 * s3 + 3 * s2;
    h11 = s3 - s2;
    for (int a = 0; a < 3; a++) begin
      p0 = longint'(signed'(key_p[a][i0]));
      p1 = longint'(signed'(key_p[a][k]));
      p2 = longint'(signed'(key_p[a][k+1]));
      p3 = longint'(signed'(key_p[a][i3]));
      d1 = round_near(f1 * (p2 - p0), 20);
      d2 = round_near(f2 * (p3 - p1), 20);
      acc = round_near(h00 * p1 + h10 * d1 + h01 * p2 + h11 * d2, 24);
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      case (a)
        0: r.x = acc[31:0];
        1: r.y = acc[31:0];
        default: r.z = acc[31:0];
      endcase
    end
    r.status = 1'b0;
    return r;
  endfunction

  assign pending = expected_pos.size();

  always @(posedge clk) begin
    pos_t got, exp_w;
    if (!rst_n) begin
      tension_q <= 16'd4915;
      count_q   <= 7'd7;
      errors = 0;
      expected_pos.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == kcsi_pkg::CFG_TENSION) tension_q <= cfg_wdata;
        else count_q <= cfg_wdata[6:0];
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == kcsi_pkg::OP_LOAD) begin
          key_t[in_tdata[5:0]]    <= in_tdata[37:6];
          key_p[0][in_tdata[5:0]] <= in_tdata[69:38];
          key_p[1][in_tdata[5:0]] <= in_tdata[101:70];
          key_p[2][in_tdata[5:0]] <= in_tdata[133:102];
        end else begin
          expected_pos.push_back(spline_eval(in_tdata[165:134]));
        end
      end
      if (out_tvalid && out_tready) begin
        got.x = out_tdata[31:0];
        got.y = out_tdata[63:32];
        got.z = out_tdata[95:64];
        got.status = out_tuser;
        if (expected_pos.size() == 0) begin
          $error("result word with no query waiting");
          errors++;
        end else begin
          exp_w = expected_pos.pop_front();
          if (got.x !== exp_w.x) begin
            $error("pos_x expected %h actual %h", exp_w.x, got.x);
            errors++;
          end
          if (got.y !== exp_w.y) begin
            $error("pos_y expected %h actual %h", exp_w.y, got.y);
            errors++;
          end
          if (got.z !== exp_w.z) begin
            $error("pos_z expected %h actual %h", exp_w.z, got.z);
            errors++;
          end
          if (got.status !== exp_w.status) begin
            $error("status expected %0d actual %0d", exp_w.status, got.status);
            errors++;
          end
        end
      end
    end
  end

endmodule

// File: tb/sv/keyframe_cardinal_spline_interp_tb.sv
// ----------------------------------------------------------------------------
// keyframe_cardinal_spline_interp_tb
// Drives load and query words into the spline interpolator over several
// tension and key count settings, with random idling on both channels and
// one long result stall; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module keyframe_cardinal_spline_interp_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 3000000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [167:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;
  logic         out_tuser;
  logic         cfg_we = 1'b0;
  logic         cfg_addr = 1'b0;
  logic [15:0]  cfg_wdata = '0;
  int           errors;
  int           pending;

  int          words_sent = 0;
  bit          quiet = 1'b0;
  bit          hold_go = 1'b0;
  logic [31:0] key_times [64];
  int          live_keys = 7;

  always #4 clk = ~clk;

  keyframe_cardinal_spline_interp dut (.*);

  kcsi_checker u_checker (.*);

  always @(posedge clk) begin
    int cycles;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    wait (rst_n);
    forever begin
      if (hold_go) begin
        hold_go = 1'b0;
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_word(logic op, logic [5:0] idx, logic [31:0] kt, logic [31:0] px,
                           logic [31:0] py, logic [31:0] pz, logic [31:0] qt);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, qt, pz, py, px, kt, idx};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (op == kcsi_pkg::OP_LOAD) key_times[idx] = kt;
  endtask

  task automatic load_key(int idx, logic [31:0] kt, logic [31:0] px, logic [31:0] py,
                          logic [31:0] pz);
    send_word(kcsi_pkg::OP_LOAD, idx[5:0], kt, px, py, pz, $urandom);
  endtask

  task automatic query_at(logic [31:0] qt);
    send_word(kcsi_pkg::OP_QUERY, 6'($urandom), $urandom, $urandom, $urandom, $urandom, qt);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic addr, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (addr == kcsi_pkg::CFG_KEY_COUNT)
      live_keys = (val[6:0] < 3) ? 3 : (val[6:0] > 64) ? 64 : int'(val[6:0]);
  endtask

  function automatic logic [31:0] rand_pos();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
  endfunction

  task automatic load_set(int mode);
    logic [31:0] t;
    t = $urandom_range(0, 32'h0010_0000);
    for (int i = 0; i < live_keys; i++) begin
      case (mode)
        0: begin
          load_key(i, t, rand_pos(), rand_pos(), rand_pos());
          t += $urandom_range(1, 32'h0004_0000);
        end
        1: load_key(i, (i == live_keys - 1) ? 32'hFFFF_FFFF : i * (32'hFFFF_FFFF / (live_keys - 1)),
                    $urandom, $urandom, $urandom);
        default: load_key(i, $urandom, rand_pos(), rand_pos(), rand_pos());
      endcase
    end
  endtask

  task automatic random_query();
    int          k;
    logic [31:0] lo, hi;
    k = $urandom_range(0, live_keys - 2);
    lo = key_times[k];
    hi = key_times[k + 1];
    case ($urandom_range(0, 9))
      0: query_at($urandom);
      1: query_at(key_times[0] - 1);
      2: query_at(key_times[live_keys - 1] + 1);
      3: query_at(key_times[$urandom_range(0, live_keys - 1)]);
      default: query_at(lo <= hi ? $urandom_range(hi, lo) : $urandom);
    endcase
  endtask

  initial begin
    logic [15:0] tensions [6];
    logic [15:0] counts [8];
    tensions = '{16'd0, 16'hFFFF, 16'd4915, 16'd4096, 16'd1, 16'd8192};
    counts   = '{16'd3, 16'd64, 16'd0, 16'd127, 16'd5, 16'd2, 16'd16, 16'd7};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes of times and positions with the reset settings
    load_key(0, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    load_key(1, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    load_key(2, 32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
    load_key(3, 32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0002_0000);
    load_key(4, 32'h0003_0000, 32'h0000_0000, 32'h0001_0000, 32'h0003_0000);
    load_key(5, 32'h0002_8000, 32'h0010_0000, 32'hFFF0_0000, 32'h0004_0000);
    load_key(6, 32'hFFFF_FFFF, 32'h0020_0000, 32'h0000_0000, 32'h7FFF_FFFF);
    query_at(32'h0000_0000);
    query_at(32'hFFFF_FFFF);
    query_at(32'h0000_8000);
    query_at(32'h0001_8000);
    query_at(32'h0002_C000);
    query_at(32'h0003_0000);
    query_at(32'h8000_0000);
    load_key(0, 32'h0000_0100, 32'h0, 32'h0, 32'h0);
    query_at(32'h0000_0000);
    load_key(6, 32'h0000_0000, 32'h0, 32'h0, 32'h0);
    query_at(32'h0000_0100);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      write_reg(kcsi_pkg::CFG_TENSION, ph < 6 ? tensions[ph] : 16'($urandom));
      write_reg(kcsi_pkg::CFG_KEY_COUNT, ph < 8 ? counts[ph] : 16'($urandom_range(3, 64)));
      load_set(ph == 1 ? 1 : (ph % 5 == 4) ? 2 : 0);
      if (ph == 2) hold_go = 1'b1;
      for (int q = 0; q < 18; q++) begin
        if (words_sent > 470) quiet = 1'b1;
        if ($urandom_range(0, 7) == 0)
          load_key($urandom_range(0, live_keys - 1), $urandom, rand_pos(), rand_pos(),
                   rand_pos());
        random_query();
      end
      drain();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/kcsi_pkg.sv
rtl/kcsi_ram.sv
rtl/kcsi_alu.sv
rtl/keyframe_cardinal_spline_interp.sv
tb/sv/kcsi_checker.sv
tb/sv/keyframe_cardinal_spline_interp_tb.sv
